[rtl/fdn8_pkg.sv]
package fdn8_pkg;

    localparam int CHANNELS       = 8;
    localparam int CH_W           = 3;
    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
    localparam int STATE_BITS     = SAMPLE_BITS + 8;
    localparam int POS_W          = 11;
    localparam int STORE_DEPTH    = 11024;
    localparam int ADDR_W         = 14;
    localparam int REG_IDX_W      = 2;
    localparam int STEP_W         = 7;

    localparam logic [CH_W-1:0]   CH_LAST    = CH_W'(CHANNELS - 1);
    localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(STORE_DEPTH - 1);

    // line lengths and their start addresses in the shared store
    localparam logic [POS_W-1:0] LINE_LEN [CHANNELS] = '{
        11'd1557, 11'd1617, 11'd1491, 11'd1422, 11'd1277, 11'd1356, 11'd1188, 11'd1116
    };
    localparam logic [ADDR_W-1:0] LINE_BASE [CHANNELS] = '{
        14'd0, 14'd1557, 14'd3174, 14'd4665, 14'd6087, 14'd7364, 14'd8720, 14'd9908
    };

    localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
    localparam logic [GAIN_W-1:0] ROOM_MIN   = 17'd6554;
    localparam logic [15:0]       K84        = 16'd55050;
    localparam logic [17:0]       SQRT_CH    = 18'd185363;
    localparam logic [61:0]       ENERGY_THR = 62'd439;
    localparam logic [6:0]        DIV_SHIFT0 = 7'd26;
    localparam logic [STEP_W-1:0] SQRT_LAST  = 7'd30;
    localparam logic [STEP_W-1:0] DIV_LAST   = 7'd64;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_ROOM = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DAMP = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WET  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_DRY  = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_START, OP_RD, OP_DIFF, OP_DMUL, OP_DUPD, OP_GMUL,
        OP_GSTO, OP_WET, OP_HSUB, OP_ESQ, OP_EACC, OP_NINIT, OP_NSHIFT,
        OP_SQINIT, OP_SQSTEP, OP_DVINIT, OP_DVSTEP, OP_SCMUL, OP_SCFIN,
        OP_WR, OP_OUT1, OP_OUT2, OP_OUT3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CH_W-1:0]   ch;
        logic [ADDR_W-1:0] clr_addr;
    } cmd_t;

    typedef struct packed {
        logic above_thr;
        logic need_shift;
        logic out_free;
    } stat_t;

    localparam logic signed [35:0] ST_MAX  = 36'sd2147483647;
    localparam logic signed [35:0] ST_MIN  = -36'sd2147483648;
    localparam logic signed [43:0] SMP_MAX = 44'sd8388607;
    localparam logic signed [43:0] SMP_MIN = -44'sd8388608;

    function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [35:0] v);
        logic signed [STATE_BITS-1:0] r;
        if (v > ST_MAX)
            r = ST_MAX[STATE_BITS-1:0];
        else if (v < ST_MIN)
            r = ST_MIN[STATE_BITS-1:0];
        else
            r = v[STATE_BITS-1:0];
        return r;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [43:0] v);
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > SMP_MAX)
            r = SMP_MAX[SAMPLE_BITS-1:0];
        else if (v < SMP_MIN)
            r = SMP_MIN[SAMPLE_BITS-1:0];
        else
            r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

endpackage

[rtl/fdn8_ram.sv]
module fdn8_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/fdn8_ctrl.sv]
module fdn8_ctrl
    import fdn8_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b000_0000_0001,
        ST_IDLE  = 11'b000_0000_0010,
        ST_LINE  = 11'b000_0000_0100,
        ST_MIX   = 11'b000_0000_1000,
        ST_HOUSE = 11'b000_0001_0000,
        ST_ECHK  = 11'b000_0010_0000,
        ST_NORM  = 11'b000_0100_0000,
        ST_SQRT  = 11'b000_1000_0000,
        ST_DIV   = 11'b001_0000_0000,
        ST_WRITE = 11'b010_0000_0000,
        ST_OUTP  = 11'b100_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ch_reg    <= '0;
            step_reg  <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            step_reg  <= step_next;
            clr_reg   <= clr_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        step_next    = step_reg;
        clr_next     = clr_reg;
        cmd.op       = OP_NONE;
        cmd.ch       = ch_reg;
        cmd.clr_addr = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op   = OP_CLR;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLEAR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_START;
                    state_next = ST_LINE;
                    ch_next    = '0;
                    step_next  = '0;
                end
            end
            ST_LINE:
            begin
                step_next = step_reg + 1'b1;
                unique case (step_reg)
                    7'd0:    cmd.op = OP_RD;
                    7'd1:    cmd.op = OP_DIFF;
                    7'd2:    cmd.op = OP_DMUL;
                    7'd3:    cmd.op = OP_DUPD;
                    7'd4:    cmd.op = OP_GMUL;
                    default:
                    begin
                        cmd.op    = OP_GSTO;
                        step_next = '0;
                        ch_next   = ch_reg + 1'b1;
                        if (ch_reg == CH_LAST)
                        begin
                            state_next = ST_MIX;
                        end
                    end
                endcase
            end
            ST_MIX:
            begin
                cmd.op     = OP_WET;
                state_next = ST_HOUSE;
                ch_next    = '0;
                step_next  = '0;
            end
            ST_HOUSE:
            begin
                step_next = step_reg + 1'b1;
                unique case (step_reg)
                    7'd0:    cmd.op = OP_HSUB;
                    7'd1:    cmd.op = OP_ESQ;
                    default:
                    begin
                        cmd.op    = OP_EACC;
                        step_next = '0;
                        ch_next   = ch_reg + 1'b1;
                        if (ch_reg == CH_LAST)
                        begin
                            state_next = ST_ECHK;
                        end
                    end
                endcase
            end
            ST_ECHK:
            begin
                ch_next = '0;
                if (stat.above_thr)
                begin
                    cmd.op     = OP_NINIT;
                    state_next = ST_NORM;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_NORM:
            begin
                if (stat.need_shift)
                begin
                    cmd.op = OP_NSHIFT;
                end
                else
                begin
                    cmd.op     = OP_SQINIT;
                    state_next = ST_SQRT;
                    step_next  = '0;
                end
            end
            ST_SQRT:
            begin
                cmd.op    = OP_SQSTEP;
                step_next = step_reg + 1'b1;
                if (step_reg == SQRT_LAST)
                begin
                    state_next = ST_DIV;
                    step_next  = '0;
                    ch_next    = '0;
                end
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == '0)
                begin
                    cmd.op = OP_DVINIT;
                end
                else if (step_reg <= DIV_LAST)
                begin
                    cmd.op = OP_DVSTEP;
                end
                else if (step_reg == DIV_LAST + 7'd1)
                begin
                    cmd.op = OP_SCMUL;
                end
                else
                begin
                    cmd.op    = OP_SCFIN;
                    step_next = '0;
                    ch_next   = ch_reg + 1'b1;
                    if (ch_reg == CH_LAST)
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                cmd.op  = OP_WR;
                ch_next = ch_reg + 1'b1;
                if (ch_reg == CH_LAST)
                begin
                    state_next = ST_OUTP;
                    step_next  = '0;
                end
            end
            ST_OUTP:
            begin
                if (step_reg == 7'd0)
                begin
                    cmd.op    = OP_OUT1;
                    step_next = 7'd1;
                end
                else if (step_reg == 7'd1)
                begin
                    cmd.op    = OP_OUT2;
                    step_next = 7'd2;
                end
                else if (stat.out_free)
                begin
                    cmd.op     = OP_OUT3;
                    state_next = ST_IDLE;
                    step_next  = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/fdn8_dp.sv]
module fdn8_dp
    import fdn8_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output stat_t                         stat,
    input  logic                          cfg_we,
    input  logic [REG_IDX_W-1:0]          cfg_index,
    input  logic [GAIN_W-1:0]             cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic signed [SAMPLE_BITS-1:0] wet_sample
);

    // configuration
    logic [GAIN_W-1:0] room_reg, damp_reg, wetg_reg, dryg_reg;
    logic [GAIN_W-1:0] room_c, damp_c, wetg_c, dryg_c;

    // per-line state
    logic [POS_W-1:0]                  pos_reg [CHANNELS];
    logic signed [STATE_BITS-1:0]      st_reg  [CHANNELS];
    logic signed [STATE_BITS-1:0]      g_reg   [CHANNELS];

    // working registers
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [33:0]                   fbq_prod_reg;
    logic [15:0]                   fbq_reg;
    logic signed [STATE_BITS-1:0]  diff_reg, s_reg;
    logic signed [49:0]            prod_reg;
    logic signed [48:0]            gprod_reg;
    logic signed [34:0]            sum_reg, hsum_reg;
    logic signed [SAMPLE_BITS-1:0] wet_reg;
    logic signed [32:0]            corr_reg;
    logic [29:0]                   m_reg;
    logic [59:0]                   sq_reg;
    logic [61:0]                   energy_reg, e_reg, sx_reg;
    logic [4:0]                    sh_reg;
    logic [60:0]                   res_reg, bit_reg;
    logic [63:0]                   num_reg;
    logic [31:0]                   rem_reg, q_reg;
    logic [49:0]                   p_reg;
    logic signed [41:0]            dp_reg, wp_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg, wet_out_reg;

    // RAM port
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr, ram_addr;
    logic [STATE_BITS-1:0]         ram_wdata, ram_rdata;

    // combinational terms
    logic signed [STATE_BITS-1:0] g_cur, st_cur, diff_sat, s_new, gs, wr_val;
    logic signed [33:0]           upd;
    logic signed [32:0]           gv;
    logic [31:0]                  gs_abs, mag;
    logic signed [34:0]           sum_adj, hsum_adj;
    logic [60:0]                  trial;
    logic [32:0]                  rem2, rem_sub;
    logic [27:0]                  v_mag;
    logic signed [42:0]           mix;
    logic [POS_W-1:0]             pos_cur;

    function automatic logic [GAIN_W-1:0] clamp_hi(input logic [GAIN_W-1:0] v);
        return (v > GAIN_ONE) ? GAIN_ONE : v;
    endfunction

    always_comb
    begin
        room_c = clamp_hi(room_reg);
        if (room_c < ROOM_MIN)
        begin
            room_c = ROOM_MIN;
        end
        damp_c = clamp_hi(damp_reg);
        wetg_c = clamp_hi(wetg_reg);
        dryg_c = clamp_hi(dryg_reg);
    end

    assign g_cur    = g_reg[cmd.ch];
    assign st_cur   = st_reg[cmd.ch];
    assign pos_cur  = pos_reg[cmd.ch];
    assign ram_addr = LINE_BASE[cmd.ch] + ADDR_W'(pos_cur);

    assign diff_sat = sat_state(36'(signed'(ram_rdata)) - 36'(st_cur));
    assign upd      = 34'((prod_reg + 50'sd32768) >>> GAIN_FRAC_BITS);
    assign s_new    = sat_state(36'(st_cur) + 36'(upd));
    assign gv       = 33'((gprod_reg + 49'sd32768) >>> GAIN_FRAC_BITS);

    // truncate toward zero: bias negatives before the floor shift
    assign sum_adj  = sum_reg + (sum_reg[34] ? 35'sd7 : 35'sd0);
    assign hsum_adj = hsum_reg + (hsum_reg[34] ? 35'sd3 : 35'sd0);

    assign gs     = sat_state(36'(g_cur) - 36'(corr_reg));
    assign gs_abs = gs[STATE_BITS-1] ? 32'(-gs) : 32'(gs);
    assign mag    = g_cur[STATE_BITS-1] ? 32'(-g_cur) : 32'(g_cur);

    assign trial   = res_reg + bit_reg;
    assign rem2    = {rem_reg, num_reg[63]};
    assign rem_sub = rem2 - {1'b0, res_reg[31:0]};

    assign v_mag  = 28'((p_reg + 50'd2097152) >> 22);
    assign wr_val = sat_state(36'(g_cur) + 36'(x_reg >>> 2));
    assign mix    = 43'(dp_reg) + 43'(wp_reg) + 43'sd32768;

    assign ram_we    = (cmd.op == OP_CLR) || (cmd.op == OP_WR);
    assign ram_waddr = (cmd.op == OP_CLR) ? cmd.clr_addr : ram_addr;
    assign ram_wdata = (cmd.op == OP_CLR) ? '0 : wr_val;

    fdn8_ram #(
        .WIDTH (STATE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // state that reset defines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_reg      <= GAIN_ONE;
            damp_reg      <= 17'd32768;
            wetg_reg      <= 17'd19661;
            dryg_reg      <= 17'd45875;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i] <= '0;
                st_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ROOM: room_reg <= cfg_data;
                    REG_DAMP: damp_reg <= cfg_data;
                    REG_WET:  wetg_reg <= cfg_data;
                    REG_DRY:  dryg_reg <= cfg_data;
                endcase
            end
            if (cmd.op == OP_OUT3)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.op == OP_DUPD)
            begin
                st_reg[cmd.ch] <= s_new;
            end
            if (cmd.op == OP_WR)
            begin
                pos_reg[cmd.ch] <= (pos_cur == LINE_LEN[cmd.ch] - 1'b1) ? '0 : pos_cur + 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_START:
            begin
                x_reg        <= in_sample;
                sum_reg      <= '0;
                hsum_reg     <= '0;
                energy_reg   <= '0;
                fbq_prod_reg <= 34'(K84) * (34'(GAIN_ONE) + 34'(room_c));
            end
            OP_RD:
            begin
                fbq_reg <= 16'((fbq_prod_reg + 34'(GAIN_ONE)) >> GAIN_W);
            end
            OP_DIFF:
            begin
                diff_reg <= diff_sat;
                sum_reg  <= sum_reg + 35'(signed'(ram_rdata));
            end
            OP_DMUL:   prod_reg  <= $signed({1'b0, damp_c}) * diff_reg;
            OP_DUPD:   s_reg     <= s_new;
            OP_GMUL:   gprod_reg <= $signed({1'b0, fbq_reg}) * s_reg;
            OP_GSTO:
            begin
                g_reg[cmd.ch] <= gv[STATE_BITS-1:0];
                hsum_reg      <= hsum_reg + 35'(gv);
            end
            OP_WET:
            begin
                wet_reg  <= sat_sample(44'(sum_adj >>> 3));
                corr_reg <= 33'(hsum_adj >>> 2);
            end
            OP_HSUB:
            begin
                g_reg[cmd.ch] <= gs;
                m_reg         <= gs_abs[31:2];
            end
            OP_ESQ:    sq_reg     <= m_reg * m_reg;
            OP_EACC:   energy_reg <= energy_reg + 62'(sq_reg);
            OP_NINIT:
            begin
                e_reg  <= energy_reg;
                sh_reg <= '0;
            end
            OP_NSHIFT:
            begin
                e_reg  <= e_reg << 2;
                sh_reg <= sh_reg + 1'b1;
            end
            OP_SQINIT:
            begin
                sx_reg  <= e_reg;
                res_reg <= '0;
                bit_reg <= 61'd1 << 60;
            end
            OP_SQSTEP:
            begin
                if (sx_reg >= 62'(trial))
                begin
                    sx_reg  <= sx_reg - 62'(trial);
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_DVINIT:
            begin
                num_reg <= {32'd0, mag} << (DIV_SHIFT0 + 7'(sh_reg));
                rem_reg <= '0;
                q_reg   <= '0;
            end
            OP_DVSTEP:
            begin
                num_reg <= num_reg << 1;
                if (!rem_sub[32])
                begin
                    rem_reg <= rem_sub[31:0];
                    q_reg   <= {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[31:0];
                    q_reg   <= {q_reg[30:0], 1'b0};
                end
            end
            OP_SCMUL:  p_reg <= q_reg * SQRT_CH;
            OP_SCFIN:
            begin
                g_reg[cmd.ch] <= g_cur[STATE_BITS-1] ? -$signed({4'd0, v_mag})
                                                     : $signed({4'd0, v_mag});
            end
            OP_OUT1:   dp_reg <= $signed({1'b0, dryg_c}) * x_reg;
            OP_OUT2:   wp_reg <= $signed({1'b0, wetg_c}) * wet_reg;
            OP_OUT3:
            begin
                out_reg     <= sat_sample(44'(mix >>> GAIN_FRAC_BITS));
                wet_out_reg <= wet_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.above_thr  = (energy_reg > ENERGY_THR);
    assign stat.need_shift = (e_reg[61:60] == 2'b00);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign out_sample = out_reg;
    assign wet_sample = wet_out_reg;

endmodule

[rtl/fdn8_householder_reverb.sv]
// Eight-line feedback delay network reverb with Householder mixing.
//
// Input channel: in_valid / in_stall / in_sample. One signed Q1.23 sample
// per item; an item is taken at a rising edge with in_valid high and in_stall
// low. in_stall stays high while an item is in flight.
// Output channel: out_valid / out_stall / out_sample, wet_sample. One result
// per item, held in an output register; it stays put while out_stall is high,
// and the block goes on taking the next input item meanwhile.
// Configuration: cfg_we / cfg_index / cfg_data, write only, while idle.
//
// Processing: every item runs the per-line damping sequence; when the feedback
// energy is above threshold the lines are also renormalised. The bulk
// of the work is then the shared restoring divider (64 steps per line, eight
// lines) and the 31-step square root; below threshold the per-line damping
// sequence dominates. The delay store is one RAM with one read or write
// per cycle.
//
// Reset: the configuration returns to its defaults, line positions and low-pass
// state clear, then a clearing pass zeroes the 11024-word delay store; input
// is stalled during that pass, configuration writes are taken as ever.
module fdn8_householder_reverb
    import fdn8_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic signed [SAMPLE_BITS-1:0] wet_sample,
    input  logic                          cfg_we,
    input  logic [REG_IDX_W-1:0]          cfg_index,
    input  logic [GAIN_W-1:0]             cfg_data
);

    // sequencer commands and datapath flags
    cmd_t  cmd;
    stat_t stat;

    // step through clear, per-line damping, mixing, normalise, write back and output
    fdn8_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold the store, line state, arithmetic units and output register
    fdn8_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_sample  (in_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample),
        .wet_sample (wet_sample)
    );

endmodule

[rtl/fdn8_checker.sv]
module fdn8_checker
    import fdn8_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] out_sample,
    input logic signed [SAMPLE_BITS-1:0] wet_sample
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(wet_sample))
        else $error("stalled result changed");

    // an accepted item keeps the input closed for a while
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
        else $error("input reopened too soon");

    // a fresh result only appears out of a busy period
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work");

endmodule

bind fdn8_householder_reverb fdn8_checker u_checker (.*);
